>>> design/bvt_pkg.sv
// Shared types and constants for the bimodal valley threshold block.
package bvt_pkg;

   // Histogram geometry
   localparam int COUNT_WIDTH_DEF = 20;
   localparam int BIN_WIDTH       = 8;
   localparam logic [BIN_WIDTH-1:0] LAST_BIN   = 8'd255;
   // First scan index at which a centered peak window is complete
   localparam logic [BIN_WIDTH-1:0] WINDOW_IDX = 8'd2;

   // Pixel kinds carried on tuser
   localparam logic KIND_COUNT    = 1'b0;
   localparam logic KIND_BINARIZE = 1'b1;

   // Binary output levels
   localparam logic [BIN_WIDTH-1:0] PIX_WHITE = 8'hFF;
   localparam logic [BIN_WIDTH-1:0] PIX_BLACK = 8'h00;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FLUSH,
      ST_PEAK,
      ST_PEAK_END,
      ST_VALLEY,
      ST_VALLEY_END,
      ST_REPORT
   } state_type;

   // Controls from the sequencer to the memory and search datapath
   typedef struct packed {
      logic                 zero_we;
      logic                 peak_rd;
      logic                 valley_rd;
      logic                 search_start;
      logic [BIN_WIDTH-1:0] scan_addr;
   } ctrl_type;

endpackage

>>> design/bvt_hist_mem.sv
// Histogram memory: one write port, one read port, registered read data.
module bvt_hist_mem #(
   parameter int COUNT_WIDTH = bvt_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [bvt_pkg::BIN_WIDTH-1:0] wr_addr,
   input  logic [COUNT_WIDTH-1:0]        wr_data,
   input  logic [bvt_pkg::BIN_WIDTH-1:0] rd_addr,
   output logic [COUNT_WIDTH-1:0]        rd_data
);

   logic [COUNT_WIDTH-1:0] mem [2**bvt_pkg::BIN_WIDTH];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   // Read returns the value held before a write at the same edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bvt_ctrl.sv
// Sequencer: clear sweep, peak scan, valley scan with clearing, report.
module bvt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              last_count,   // counting pixel with last transferred
   input  logic              rsp_free,     // result register can take a new item
   output logic              idle,
   output logic              report_load,
   output bvt_pkg::ctrl_type ctrl
);

   bvt_pkg::state_type state_ff, state_in;
   logic [bvt_pkg::BIN_WIDTH-1:0] scan_ff, scan_in;
   logic scanning;
   logic scan_end;

   assign scanning = (state_ff == bvt_pkg::ST_CLEAR) || (state_ff == bvt_pkg::ST_PEAK) ||
                     (state_ff == bvt_pkg::ST_VALLEY);
   assign scan_end = (scan_ff == bvt_pkg::LAST_BIN);
   assign scan_in  = scanning ? scan_ff + 1'b1 : '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bvt_pkg::ST_CLEAR:      if (scan_end) state_in = bvt_pkg::ST_IDLE;
         bvt_pkg::ST_IDLE:       if (last_count) state_in = bvt_pkg::ST_FLUSH;
         bvt_pkg::ST_FLUSH:      state_in = bvt_pkg::ST_PEAK;
         bvt_pkg::ST_PEAK:       if (scan_end) state_in = bvt_pkg::ST_PEAK_END;
         bvt_pkg::ST_PEAK_END:   state_in = bvt_pkg::ST_VALLEY;
         bvt_pkg::ST_VALLEY:     if (scan_end) state_in = bvt_pkg::ST_VALLEY_END;
         bvt_pkg::ST_VALLEY_END: state_in = bvt_pkg::ST_REPORT;
         bvt_pkg::ST_REPORT:     if (rsp_free) state_in = bvt_pkg::ST_IDLE;
         default:                state_in = bvt_pkg::ST_CLEAR;
      endcase
   end

   // Outputs
   always_comb begin
      ctrl.zero_we      = (state_ff == bvt_pkg::ST_CLEAR) || (state_ff == bvt_pkg::ST_VALLEY);
      ctrl.peak_rd      = (state_ff == bvt_pkg::ST_PEAK);
      ctrl.valley_rd    = (state_ff == bvt_pkg::ST_VALLEY);
      ctrl.search_start = (state_ff == bvt_pkg::ST_FLUSH);
      ctrl.scan_addr    = scan_ff;
      idle              = (state_ff == bvt_pkg::ST_IDLE);
      report_load       = (state_ff == bvt_pkg::ST_REPORT) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bvt_pkg::ST_CLEAR;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

endmodule

>>> design/bvt_search.sv
// Peak and valley search over the histogram as it streams out of memory.
module bvt_search #(
   parameter int COUNT_WIDTH = bvt_pkg::COUNT_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bvt_pkg::ctrl_type             ctrl,
   input  logic [COUNT_WIDTH-1:0]        rd_data,
   output logic [bvt_pkg::BIN_WIDTH-1:0] threshold,
   output logic [bvt_pkg::BIN_WIDTH-1:0] tallest_peak,
   output logic [bvt_pkg::BIN_WIDTH-1:0] second_peak
);

   localparam int BW = bvt_pkg::BIN_WIDTH;

   logic                   pk_vld_ff, vl_vld_ff;
   logic [BW-1:0]          idx_ff;
   logic [COUNT_WIDTH-1:0] win1_ff, win2_ff;
   logic [COUNT_WIDTH-1:0] top_h_ff, top_h_in, sec_h_ff, sec_h_in;
   logic [BW-1:0]          top_pos_ff, top_pos_in, sec_pos_ff, sec_pos_in;
   logic [COUNT_WIDTH-1:0] min_h_ff, min_h_in, min_ref;
   logic [BW-1:0]          min_pos_ff, min_pos_in;
   logic                   found_ff, found_in;
   logic [BW-1:0]          lo_pos, hi_pos, mid_pos;
   logic                   is_peak, in_range;

   // Bin idx_ff-1 is judged against its two neighbors
   assign mid_pos = idx_ff - 1'b1;
   assign is_peak = pk_vld_ff && (idx_ff >= bvt_pkg::WINDOW_IDX) &&
                    (win1_ff > win2_ff) && (win1_ff > rd_data);

   // Valley range between the two peaks
   assign lo_pos   = (top_pos_ff < sec_pos_ff) ? top_pos_ff : sec_pos_ff;
   assign hi_pos   = (top_pos_ff < sec_pos_ff) ? sec_pos_ff : top_pos_ff;
   assign in_range = vl_vld_ff && (idx_ff >= lo_pos) && (idx_ff < hi_pos);
   assign min_ref  = found_ff ? min_h_ff : top_h_ff;

   // Peak ranking
   always_comb begin
      top_h_in   = top_h_ff;
      top_pos_in = top_pos_ff;
      sec_h_in   = sec_h_ff;
      sec_pos_in = sec_pos_ff;
      if (ctrl.search_start) begin
         top_h_in   = '0;
         top_pos_in = '0;
         sec_h_in   = '0;
         sec_pos_in = '0;
      end else if (is_peak) begin
         if (win1_ff > top_h_ff) begin
            sec_h_in   = top_h_ff;
            sec_pos_in = top_pos_ff;
            top_h_in   = win1_ff;
            top_pos_in = mid_pos;
         end else if (win1_ff > sec_h_ff) begin
            sec_h_in   = win1_ff;
            sec_pos_in = mid_pos;
         end
      end
   end

   // Running minimum, first strict drop wins
   always_comb begin
      min_h_in   = min_h_ff;
      min_pos_in = min_pos_ff;
      found_in   = found_ff;
      if (ctrl.search_start) begin
         found_in = 1'b0;
      end else if (in_range && (min_ref > rd_data)) begin
         min_h_in   = rd_data;
         min_pos_in = idx_ff;
         found_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pk_vld_ff <= 1'b0;
         vl_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         pk_vld_ff <= ctrl.peak_rd;
         vl_vld_ff <= ctrl.valley_rd;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= ctrl.scan_addr;
      if (pk_vld_ff) begin
         win1_ff <= rd_data;
         win2_ff <= win1_ff;
      end
      top_h_ff   <= top_h_in;
      top_pos_ff <= top_pos_in;
      sec_h_ff   <= sec_h_in;
      sec_pos_ff <= sec_pos_in;
      min_h_ff   <= min_h_in;
      min_pos_ff <= min_pos_in;
   end

   assign threshold    = found_ff ? min_pos_ff : lo_pos;
   assign tallest_peak = top_pos_ff;
   assign second_peak  = sec_pos_ff;

endmodule

>>> design/bimodal_valley_threshold.sv
// Top level of the bimodal valley threshold block.
//
// Input stream (req_): one 8-bit gray pixel per transfer on req_tdata, the
// pass on req_tuser (0 = count into the histogram, 1 = binarize) and
// req_tlast marking the final pixel of a counting pass.
// Result stream (rsp_): rsp_tuser = 1 for a threshold report, 0 for a
// binary pixel; rsp_tdata carries binary pixel, threshold, tallest and
// second peak bins, one byte each from the low end.
// Pixels are taken one per cycle while req_tready is high. A counting pixel
// gives no result; its bin is updated by a read-modify-write in a 256-entry
// memory with forwarding between back-to-back pixels on the same bin. A
// binarizing pixel's result is registered and appears in the cycle after its
// input transfer. After a counting pixel with tlast, req_tready stays low
// through a flush state that retires the last write, a peak scan and a valley
// scan that zeroes the histogram, an end state after each scan for its last
// bin and a report state that loads the report; each scan reads one bin per
// cycle. Reset clears the histogram in a sweep with req_tready low and
// sets the kept threshold to zero. While the receiver holds rsp_tready
// low, the pending result holds and no new input is taken.
module bimodal_valley_threshold #(
   parameter int COUNT_WIDTH = bvt_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   input  logic        req_tuser,   // [0] kind
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] binary_pixel, [15:8] threshold,
                                    // [23:16] tallest_peak, [31:24] second_peak
   output logic        rsp_tuser    // [0] report
);

   localparam int BW = bvt_pkg::BIN_WIDTH;

   bvt_pkg::ctrl_type      ctrl;
   logic                   idle, report_load, rsp_free;
   logic                   req_xfer, count_xfer, bin_xfer, last_count;
   logic                   s1_vld_ff, wr_vld_ff;
   logic [BW-1:0]          s1_addr_ff, wr_addr_ff;
   logic [COUNT_WIDTH-1:0] wr_data_ff, cnt_base, cnt_next, mem_rd_data;
   logic                   mem_we;
   logic [BW-1:0]          mem_wa, mem_ra;
   logic [COUNT_WIDTH-1:0] mem_wd;
   logic [BW-1:0]          thr_ff, srch_thr, srch_top, srch_sec, bin_pix;
   logic                   rsp_valid_ff, rsp_valid_in, rsp_user_ff;
   logic [31:0]            rsp_data_ff;

   // Input transfer decode
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = idle && rsp_free;
   assign req_xfer   = req_tvalid && req_tready;
   assign count_xfer = req_xfer && (req_tuser == bvt_pkg::KIND_COUNT);
   assign bin_xfer   = req_xfer && (req_tuser == bvt_pkg::KIND_BINARIZE);
   assign last_count = count_xfer && req_tlast;

   // Saturating increment, forwarding the previous write to the same bin
   assign cnt_base = (wr_vld_ff && (wr_addr_ff == s1_addr_ff)) ? wr_data_ff : mem_rd_data;
   assign cnt_next = (cnt_base == {COUNT_WIDTH{1'b1}}) ? cnt_base
                                                       : cnt_base + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   // Memory port muxing: scans own the ports outside the counting pass
   assign mem_we = ctrl.zero_we || s1_vld_ff;
   assign mem_wa = ctrl.zero_we ? ctrl.scan_addr : s1_addr_ff;
   assign mem_wd = ctrl.zero_we ? '0 : cnt_next;
   assign mem_ra = (ctrl.peak_rd || ctrl.valley_rd) ? ctrl.scan_addr : req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         wr_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= count_xfer;
         wr_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= req_tdata;
      wr_addr_ff <= s1_addr_ff;
      wr_data_ff <= cnt_next;
   end

   bvt_hist_mem #(.COUNT_WIDTH(COUNT_WIDTH)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd_data)
   );

   bvt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .last_count  (last_count),
      .rsp_free    (rsp_free),
      .idle        (idle),
      .report_load (report_load),
      .ctrl        (ctrl)
   );

   bvt_search #(.COUNT_WIDTH(COUNT_WIDTH)) u_search (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .rd_data      (mem_rd_data),
      .threshold    (srch_thr),
      .tallest_peak (srch_top),
      .second_peak  (srch_sec)
   );

   // Kept threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (report_load) begin
         thr_ff <= srch_thr;
      end
   end

   // Result register
   assign bin_pix      = (req_tdata > thr_ff) ? bvt_pkg::PIX_WHITE : bvt_pkg::PIX_BLACK;
   assign rsp_valid_in = (bin_xfer || report_load) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (report_load) begin
         rsp_user_ff <= 1'b1;
         rsp_data_ff <= {srch_sec, srch_top, srch_thr, bvt_pkg::PIX_BLACK};
      end else if (bin_xfer) begin
         rsp_user_ff <= 1'b0;
         rsp_data_ff <= {{(2*BW){1'b0}}, thr_ff, bin_pix};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> design/bvt_checker.sv
// Port-level checks for the bimodal valley threshold block, bound to the top.
module bvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Histogram clear sweep follows reset
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input taken during reset clear");

   // The search starts right after the last counting pixel
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == 1'b0) && req_tlast |=> !req_tready)
      else $error("input taken during threshold search");

   // Every binarizing transfer yields a binary pixel next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == 1'b1) |=> rsp_tvalid && !rsp_tuser)
      else $error("binary pixel result missing");

   // Binary pixels are black or white with no peak fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         ((rsp_tdata[7:0] == 8'h00) || (rsp_tdata[7:0] == 8'hFF)) && (rsp_tdata[31:16] == 16'h0))
      else $error("malformed binary pixel result");

endmodule

bind bimodal_valley_threshold bvt_checker u_bvt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> dv/tb_top.sv
// Stream testbench for the bimodal valley threshold block: planned pixels, predictor, checker.
`timescale 1ns / 1ps

module tb_top;

   // Narrow bin counters so that saturation is reachable within the run
   localparam int CNT_W = 8;
   localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};
   localparam int BINS = 256;
   localparam int PLAN_ITEMS = 1500;
   localparam int CALM_ITEMS = 120;
   localparam int DRAIN_CYCLES = 600;

   // One planned input transfer, or a hold-off until all results are in
   typedef struct {
      logic       kind;
      logic [7:0] pix;
      logic       tl;
      bit         hold_off;
   } plan_item_type;

   // One result transfer as the block should send it
   typedef struct packed {
      logic       report;
      logic [7:0] bin_pix;
      logic [7:0] thr;
      logic [7:0] top_pk;
      logic [7:0] sec_pk;
   } pixel_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] pixel
   logic        req_tuser = 1'b0;    // [0] kind
   logic        req_tlast = 1'b0;    // last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [7:0] binary_pixel, [15:8] threshold,
                                     // [23:16] tallest_peak, [31:24] second_peak
   logic        rsp_tuser;           // [0] report

   plan_item_type    pixel_plan[$];
   pixel_result_type pending_results[$];

   // Predictor state
   logic [CNT_W-1:0] hist_ref [BINS];
   logic [7:0]       thr_ref;

   // Handshake bookkeeping
   logic req_took = 1'b0;
   bit   calm = 1'b0;
   bit   waiting_drain = 1'b0;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   req_odds = 16;
   int   rsp_odds = 16;
   int   req_tick = 0;
   int   rsp_tick = 0;

   // Run statistics
   int err_count = 0;
   int n_counted = 0;
   int n_binarized = 0;
   int n_reports = 0;
   int n_hold_offs = 0;

   bimodal_valley_threshold #(.COUNT_WIDTH(CNT_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("[bimodal_valley_threshold] ERROR");
      $finish;
   end

   // Peak pair and valley search over the predicted histogram
   function automatic pixel_result_type find_valley();
      pixel_result_type r;
      logic [CNT_W-1:0] top_h, sec_h, min_h, h;
      int               top_pos, sec_pos, lo, hi, min_pos;
      bit               found;
      top_h = '0;
      sec_h = '0;
      top_pos = 0;
      sec_pos = 0;
      found = 1'b0;
      for (int b = 1; b < BINS - 1; b++) begin
         h = hist_ref[b];
         if (h > hist_ref[b-1] && h > hist_ref[b+1]) begin
            if (h > top_h) begin
               sec_pos = top_pos;
               sec_h = top_h;
               top_pos = b;
               top_h = h;
            end else if (h > sec_h) begin
               sec_pos = b;
               sec_h = h;
            end
         end
      end
      lo = (top_pos < sec_pos) ? top_pos : sec_pos;
      hi = (top_pos < sec_pos) ? sec_pos : top_pos;
      // running minimum starts at the tallest height; first strict drop wins
      min_h = top_h;
      min_pos = lo;
      for (int b = lo; b < hi; b++) begin
         if (min_h > hist_ref[b]) begin
            min_h = hist_ref[b];
            min_pos = b;
            found = 1'b1;
         end
      end
      if (!found) min_pos = lo;
      r.report = 1'b1;
      r.bin_pix = bvt_pkg::PIX_BLACK;
      r.thr = 8'(min_pos);
      r.top_pk = 8'(top_pos);
      r.sec_pk = 8'(sec_pos);
      return r;
   endfunction

   // Advance the predictor by one accepted pixel
   task automatic predict_pixel(input logic kind, input logic [7:0] pix, input logic tl);
      pixel_result_type r;
      if (kind == bvt_pkg::KIND_COUNT) begin
         n_counted++;
         if (hist_ref[pix] != CNT_TOP) hist_ref[pix] = hist_ref[pix] + 1'b1;
         if (tl) begin
            r = find_valley();
            thr_ref = r.thr;
            for (int b = 0; b < BINS; b++) hist_ref[b] = '0;
            pending_results.push_back(r);
         end
      end else begin
         // last is ignored on binarizing pixels
         n_binarized++;
         r.report = 1'b0;
         r.bin_pix = (pix > thr_ref) ? bvt_pkg::PIX_WHITE : bvt_pkg::PIX_BLACK;
         r.thr = thr_ref;
         r.top_pk = 8'h00;
         r.sec_pk = 8'h00;
         pending_results.push_back(r);
      end
   endtask

   task automatic add_pixel(input logic kind, input int pix, input logic tl);
      plan_item_type it;
      it.kind = kind;
      it.pix = 8'(pix);
      it.tl = tl;
      it.hold_off = 1'b0;
      pixel_plan.push_back(it);
   endtask

   task automatic add_hold_off();
      plan_item_type it;
      it.kind = bvt_pkg::KIND_COUNT;
      it.pix = 8'h00;
      it.tl = 1'b0;
      it.hold_off = 1'b1;
      pixel_plan.push_back(it);
   endtask

   // Gray level scattered around a center, clamped to the pixel range
   function automatic int near_level(input int c, input int spread);
      int v;
      v = c + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   function automatic int pick_odds();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 4;
         default: return 16;
      endcase
   endfunction

   // Monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin : monitor
      pixel_result_type exp_r;
      pixel_result_type got;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_tvalid && req_tready;
         calm <= (pixel_plan.size() < CALM_ITEMS);
         if (req_tvalid && req_tready) predict_pixel(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.report = rsp_tuser;
            got.bin_pix = rsp_tdata[7:0];
            got.thr = rsp_tdata[15:8];
            got.top_pk = rsp_tdata[23:16];
            got.sec_pk = rsp_tdata[31:24];
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result transfer, actual %h", $time, got);
               err_count++;
            end else begin
               exp_r = pending_results.pop_front();
               if (got.report) n_reports++;
               if (got.report !== exp_r.report) begin
                  $display("%0t: report expected %0d actual %0d", $time, exp_r.report,
                           got.report);
                  err_count++;
               end
               if (got.bin_pix !== exp_r.bin_pix) begin
                  $display("%0t: binary_pixel expected %0d actual %0d", $time,
                           exp_r.bin_pix, got.bin_pix);
                  err_count++;
               end
               if (got.thr !== exp_r.thr) begin
                  $display("%0t: threshold expected %0d actual %0d", $time, exp_r.thr,
                           got.thr);
                  err_count++;
               end
               if (got.top_pk !== exp_r.top_pk) begin
                  $display("%0t: tallest_peak expected %0d actual %0d", $time,
                           exp_r.top_pk, got.top_pk);
                  err_count++;
               end
               if (got.sec_pk !== exp_r.sec_pk) begin
                  $display("%0t: second_peak expected %0d actual %0d", $time,
                           exp_r.sec_pk, got.sec_pk);
                  err_count++;
               end
            end
         end
      end
   end

   // Driver: present planned pixels, hold until transfer, idle in bursts
   always @(negedge clock) begin : driver
      plan_item_type it;
      logic       nxt_valid;
      logic [7:0] nxt_data;
      logic       nxt_user;
      logic       nxt_last;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
         req_tuser <= 1'b0;
         req_tlast <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         nxt_valid = 1'b0;
         nxt_data = 8'h00;
         nxt_user = 1'b0;
         nxt_last = 1'b0;
         req_tick++;
         if (req_tick % 64 == 0) req_odds = pick_odds();
         if (waiting_drain) begin
            if (pending_results.size() == 0) waiting_drain = 1'b0;
         end else if (req_gap > 0) begin
            req_gap--;
         end else if (!calm && req_odds != 0 && $urandom_range(0, req_odds - 1) == 0) begin
            req_gap = $urandom_range(1, 12) - 1;
         end else if (pixel_plan.size() > 0) begin
            it = pixel_plan.pop_front();
            if (it.hold_off) begin
               waiting_drain = 1'b1;
               n_hold_offs++;
            end else begin
               nxt_valid = 1'b1;
               nxt_data = it.pix;
               nxt_user = it.kind;
               nxt_last = it.tl;
            end
         end
         req_tvalid <= nxt_valid;
         req_tdata <= nxt_data;
         req_tuser <= nxt_user;
         req_tlast <= nxt_last;
      end
   end

   // Receiver: ready with random stall bursts
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tick++;
         if (rsp_tick % 64 == 0) rsp_odds = pick_odds();
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && rsp_odds != 0 && $urandom_range(0, rsp_odds - 1) == 0) begin
            rsp_gap = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Plan the stimulus, release reset, wait for the drain, report
   initial begin : sequencer
      int         mode, n, m, c1, c2, spr, p, frames;
      logic [7:0] seen[$];
      for (int b = 0; b < BINS; b++) hist_ref[b] = '0;
      thr_ref = 8'h00;
      frames = 0;

      // binarize before any count: threshold still zero, last ignored
      add_pixel(bvt_pkg::KIND_BINARIZE, 0, 1'b0);
      add_pixel(bvt_pkg::KIND_BINARIZE, 1, 1'b0);
      add_pixel(bvt_pkg::KIND_BINARIZE, 255, 1'b1);
      // counts only in the edge bins: no peak at all
      add_pixel(bvt_pkg::KIND_COUNT, 0, 1'b1);
      add_pixel(bvt_pkg::KIND_COUNT, 255, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 0, 1'b1);
      // peaks on the outermost searchable bins
      add_pixel(bvt_pkg::KIND_COUNT, 254, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 254, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 1, 1'b1);
      // two peaks of equal height: the first stays tallest
      add_pixel(bvt_pkg::KIND_COUNT, 50, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 50, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 60, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 60, 1'b1);
      // binarize around the new threshold: equal, above, below
      add_pixel(bvt_pkg::KIND_BINARIZE, 51, 1'b0);
      add_pixel(bvt_pkg::KIND_BINARIZE, 52, 1'b0);
      add_pixel(bvt_pkg::KIND_BINARIZE, 50, 1'b0);
      // three peaks: a later one displaces the second
      add_pixel(bvt_pkg::KIND_COUNT, 100, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 100, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 100, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 120, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 140, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 140, 1'b1);
      add_hold_off();

      // one bin driven into saturation, back to back on the same bin
      repeat (280) add_pixel(bvt_pkg::KIND_COUNT, 128, 1'b0);
      repeat (4) add_pixel(bvt_pkg::KIND_COUNT, 200, 1'b0);
      add_pixel(bvt_pkg::KIND_COUNT, 200, 1'b1);
      add_pixel(bvt_pkg::KIND_BINARIZE, 128, 1'b0);
      add_pixel(bvt_pkg::KIND_BINARIZE, 129, 1'b0);
      add_pixel(bvt_pkg::KIND_BINARIZE, 130, 1'b1);

      // random frames: counting pass closed by last, then a binarizing pass
      while (pixel_plan.size() < PLAN_ITEMS) begin
         frames++;
         if (frames % 12 == 0) add_hold_off();
         seen.delete();
         mode = $urandom_range(0, 9);
         c1 = $urandom_range(0, 255);
         c2 = $urandom_range(0, 255);
         spr = $urandom_range(0, 8);
         if (mode inside {[0:5]}) begin
            n = $urandom_range(4, 40);
         end else begin
            case (mode)
               6: n = $urandom_range(1, 30);
               7: n = $urandom_range(1, 3);
               8: n = $urandom_range(1, 12);
               default: n = 0;
            endcase
         end
         for (int i = 0; i < n; i++) begin
            if (mode inside {[0:5]}) begin
               p = near_level(($urandom_range(0, 2) == 0) ? c2 : c1, spr);
            end else if (mode == 8) begin
               case ($urandom_range(0, 3))
                  0: p = 0;
                  1: p = 1;
                  2: p = 254;
                  default: p = 255;
               endcase
            end else begin
               p = $urandom_range(0, 255);
            end
            seen.push_back(8'(p));
            // stray binarizing pixel inside a counting pass
            if ($urandom_range(0, 15) == 0)
               add_pixel(bvt_pkg::KIND_BINARIZE, $urandom_range(0, 255),
                         1'($urandom_range(0, 1)));
            add_pixel(bvt_pkg::KIND_COUNT, p, (i == n - 1));
         end
         // binarizing pass, mostly near the counted levels
         m = $urandom_range(0, 30);
         for (int i = 0; i < m; i++) begin
            if (seen.size() > 0 && $urandom_range(0, 2) != 0)
               p = near_level(seen[$urandom_range(0, seen.size() - 1)], 1);
            else
               p = $urandom_range(0, 255);
            add_pixel(bvt_pkg::KIND_BINARIZE, p, 1'($urandom_range(0, 1)));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pixel_plan.size() != 0 || req_tvalid || waiting_drain) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d counted and %0d binarized pixels, %0d threshold reports,",
               n_counted, n_binarized, n_reports);
      $display("edge bins, peak ties, one saturated bin and %0d full drains.", n_hold_offs);
      if (err_count == 0) begin
         $display("[bimodal_valley_threshold] OK");
      end else begin
         $display("[bimodal_valley_threshold] ERROR");
      end
      $finish;
   end

endmodule
